// ----- design/yuv_box_downscaler_core_assert.svh -----
// Assertion macros for the YUV box downscaler.
// Used by yuv_box_downscaler_core; expects clk_i and rst_ni in scope.
`ifndef YUV_BOX_DOWNSCALER_CORE_ASSERT_SVH
`define YUV_BOX_DOWNSCALER_CORE_ASSERT_SVH
`ifndef SYNTH
`define YBD_ASSERT(name, prop) name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("yuv_box_downscaler_core: check failed");
`define YBD_ASSERT_NEVER(name, cond) `YBD_ASSERT(name, !(cond))
`else
`define YBD_ASSERT(name, prop)
`define YBD_ASSERT_NEVER(name, cond)
`endif
`endif

// ----- design/yuv_bds_pkg.sv -----
// Shared types and constants of the YUV box downscaler.
// No dependencies; used by yuv_box_downscaler_core.
package yuv_bds_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned PixW      = 3 * SampleW;
  localparam int unsigned DimW      = 14;
  localparam int unsigned RowW      = 13;
  localparam int unsigned SumW      = 14;
  localparam int unsigned LineSlots = 3;

  localparam logic [DimW-1:0] MaxHeight = 14'd8192;
  localparam logic [3:0]      Factor2   = 4'd2;
  localparam logic [3:0]      Factor4   = 4'd4;
  localparam logic [1:0]      PatCosited = 2'd0;

  // Configuration register indexes.
  localparam logic [2:0] CfgEnable  = 3'd0;
  localparam logic [2:0] CfgPattern = 3'd1;
  localparam logic [2:0] CfgFactor  = 3'd2;
  localparam logic [2:0] CfgWidth   = 3'd3;
  localparam logic [2:0] CfgHeight  = 3'd4;

  // Luma sits in the low bits, matching the line store word layout.
  typedef struct packed {
    logic [SampleW-1:0] cr_in;
    logic [SampleW-1:0] cb_in;
    logic [SampleW-1:0] luma_in;
  } pix_in_t;

  typedef struct packed {
    logic [SampleW-1:0] cr_out;
    logic [SampleW-1:0] cb_out;
    logic [SampleW-1:0] luma_out;
  } pix_out_t;

endpackage

// ----- design/yuv_bds_ram.sv -----
// Generic single-port RAM with registered read data for the line stores.
// No dependencies.
module yuv_bds_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/yuv_box_downscaler_core.sv -----
// Top level of the YUV box downscaler (2x2 / 4x4 box average or pass-through).
// Depends on yuv_bds_pkg, yuv_bds_ram and yuv_box_downscaler_core_assert.svh.
//
// The core takes one pixel beat per clock while in_ready_o is high and keeps
// the raster position itself from the configured frame size. A beat is
// decoded at acceptance, where its line store read or write is issued; in the
// next cycle the line data and the running horizontal sum form the result,
// which enters a three-entry output queue. Sustained rate is one pixel per
// cycle while the queue drains, set by the single line store port per line.
// The line stores are min(STORED_LINES, 3) RAMs of MAX_WIDTH x 30 bits and
// need no clearing pass after reset. Configuration must be written while idle.
`include "yuv_box_downscaler_core_assert.svh"

module yuv_box_downscaler_core #(
  parameter int unsigned MAX_WIDTH    = 8192,
  parameter int unsigned STORED_LINES = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [yuv_bds_pkg::DimW-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  yuv_bds_pkg::pix_in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output yuv_bds_pkg::pix_out_t                out_data_o
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam int unsigned SW    = yuv_bds_pkg::SampleW;
  localparam int unsigned AccW  = SW + 2;

  typedef struct packed {
    logic pass;
    logic acc;
    logic f4;
    logic first;
    logic produce;
  } ctl_t;

  // Configuration registers.
  logic                         enable_q;
  logic [1:0]                   pattern_q;
  logic [3:0]                   factor_q;
  logic [yuv_bds_pkg::DimW-1:0] width_q;
  logic [yuv_bds_pkg::DimW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      pattern_q <= 2'd0;
      factor_q  <= 4'd2;
      width_q   <= 14'd1920;
      height_q  <= 14'd1080;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        yuv_bds_pkg::CfgEnable:  enable_q  <= cfg_wdata_i[0];
        yuv_bds_pkg::CfgPattern: pattern_q <= cfg_wdata_i[1:0];
        yuv_bds_pkg::CfgFactor:  factor_q  <= cfg_wdata_i[3:0];
        yuv_bds_pkg::CfgWidth:   width_q   <= cfg_wdata_i;
        yuv_bds_pkg::CfgHeight:  height_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Raster position.
  logic [AddrW-1:0]                col_q;
  logic [yuv_bds_pkg::RowW-1:0]    row_q;
  logic [yuv_bds_pkg::DimW-1:0]    w_eff;
  logic [yuv_bds_pkg::DimW-1:0]    h_eff;
  logic [yuv_bds_pkg::DimW-1:0]    col_inc;
  logic [yuv_bds_pkg::DimW-1:0]    row_inc;
  logic                            accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    if (width_q == '0) begin
      w_eff = 14'd1;
    end else if (width_q > yuv_bds_pkg::DimW'(MAX_WIDTH)) begin
      w_eff = yuv_bds_pkg::DimW'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = 14'd1;
    end else if (height_q > yuv_bds_pkg::MaxHeight) begin
      h_eff = yuv_bds_pkg::MaxHeight;
    end else begin
      h_eff = height_q;
    end
    col_inc = yuv_bds_pkg::DimW'(col_q) + 14'd1;
    row_inc = yuv_bds_pkg::DimW'(row_q) + 14'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= h_eff) ? '0 : row_inc[yuv_bds_pkg::RowW-1:0];
      end else begin
        col_q <= col_inc[AddrW-1:0];
      end
    end
  end

  // Decode of the current beat against mode and position.
  ctl_t       dec;
  logic       wr_line;
  logic       rd_line;
  logic [1:0] wr_sel;
  logic       mode_f2;
  logic       mode_f4;

  assign mode_f2 = enable_q && (pattern_q == yuv_bds_pkg::PatCosited)
                   && (factor_q == yuv_bds_pkg::Factor2);
  assign mode_f4 = enable_q && (pattern_q == yuv_bds_pkg::PatCosited)
                   && (factor_q == yuv_bds_pkg::Factor4) && (STORED_LINES >= 3);

  always_comb begin
    dec     = '0;
    wr_line = 1'b0;
    rd_line = 1'b0;
    wr_sel  = 2'd0;
    if (!enable_q) begin
      dec.pass    = 1'b1;
      dec.produce = 1'b1;
    end else if (mode_f2) begin
      if (!row_q[0]) begin
        wr_line = 1'b1;
      end else begin
        rd_line     = 1'b1;
        dec.acc     = 1'b1;
        dec.first   = !col_q[0];
        dec.produce = col_q[0];
      end
    end else if (mode_f4) begin
      if (row_q[1:0] != 2'd3) begin
        wr_line = 1'b1;
        wr_sel  = row_q[1:0];
      end else begin
        rd_line     = 1'b1;
        dec.acc     = 1'b1;
        dec.f4      = 1'b1;
        dec.first   = (col_q[1:0] == 2'd0);
        dec.produce = (col_q[1:0] == 2'd3);
      end
    end
  end

  // Line stores; slots beyond STORED_LINES read as zero and are never used.
  logic [yuv_bds_pkg::PixW-1:0] rd_data [yuv_bds_pkg::LineSlots];

  for (genvar g = 0; g < yuv_bds_pkg::LineSlots; g++) begin : g_line
    if (g < STORED_LINES) begin : g_ram
      yuv_bds_ram #(
        .WIDTH(yuv_bds_pkg::PixW),
        .DEPTH(MAX_WIDTH)
      ) u_ram (
        .clk_i  (clk_i),
        .we_i   (accept && wr_line && (wr_sel == 2'(g))),
        .re_i   (accept && rd_line),
        .addr_i (col_q),
        .wdata_i(in_data_i),
        .rdata_o(rd_data[g])
      );
    end else begin : g_none
      assign rd_data[g] = '0;
    end
  end

  // Second stage: the beat whose line data is now on the RAM outputs.
  logic                          s1_valid_q;
  ctl_t                          s1_ctl_q;
  yuv_bds_pkg::pix_in_t          s1_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctl_q   <= '0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        s1_ctl_q <= dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q <= in_data_i;
    end
  end

  logic [yuv_bds_pkg::SumW-1:0] sum_q [3];
  logic [yuv_bds_pkg::SumW-1:0] sum_d [3];
  logic [AccW-1:0]              col_add [3];
  logic [yuv_bds_pkg::PixW-1:0] px_word;
  logic [yuv_bds_pkg::PixW-1:0] box_word;
  yuv_bds_pkg::pix_out_t        result;

  assign px_word = s1_px_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      col_add[ch] = AccW'(px_word[SW*ch +: SW]) + AccW'(rd_data[0][SW*ch +: SW]);
      if (s1_ctl_q.f4) begin
        col_add[ch] = col_add[ch] + AccW'(rd_data[1][SW*ch +: SW])
                      + AccW'(rd_data[2][SW*ch +: SW]);
      end
      if (s1_ctl_q.first) begin
        sum_d[ch] = yuv_bds_pkg::SumW'(col_add[ch]);
      end else begin
        sum_d[ch] = sum_q[ch] + yuv_bds_pkg::SumW'(col_add[ch]);
      end
      // Truncating average: divide by 4 or 16.
      box_word[SW*ch +: SW] = s1_ctl_q.f4 ? sum_d[ch][13:4] : sum_d[ch][11:2];
    end
    result = s1_ctl_q.pass ? yuv_bds_pkg::pix_out_t'(px_word)
                           : yuv_bds_pkg::pix_out_t'(box_word);
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ctl_q.acc) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= sum_d[ch];
      end
    end
  end

  // Output queue. Input is taken only while the queue can absorb every beat
  // already in flight, so no result is ever dropped.
  logic [1:0]            head_q;
  logic [1:0]            tail_q;
  logic [1:0]            cnt_q;
  yuv_bds_pkg::pix_out_t fifo_q [3];
  logic                  push;
  logic                  pop;

  assign push        = s1_valid_q && s1_ctl_q.produce;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = fifo_q[head_q];
  assign in_ready_o  = (3'(cnt_q) + 3'(s1_valid_q)) <= 3'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 2'd0;
      tail_q <= 2'd0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        tail_q <= (tail_q == 2'd2) ? 2'd0 : tail_q + 2'd1;
      end
      if (pop) begin
        head_q <= (head_q == 2'd2) ? 2'd0 : head_q + 2'd1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[tail_q] <= result;
    end
  end

  `YBD_ASSERT_NEVER(a_queue_overflow, push && !pop && (cnt_q == 2'd3))
  `YBD_ASSERT(a_col_in_range, yuv_bds_pkg::DimW'(col_q) < yuv_bds_pkg::DimW'(MAX_WIDTH))
  `YBD_ASSERT(a_stage_mode_excl, s1_valid_q |-> $onehot0({s1_ctl_q.pass, s1_ctl_q.acc}))
  `YBD_ASSERT(a_result_latency, (accept && !enable_q) |=> push)

endmodule

// ----- bench/yuv_box_downscaler_checker.sv -----
// Scoreboard for the YUV box downscaler: watches config writes and both pixel channels.
// Keeps its own line stores, sums and raster position; depends on yuv_bds_pkg.
module yuv_box_downscaler_checker
  import yuv_bds_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 8192,
  parameter int unsigned STORED_LINES = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [DimW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  pix_in_t         in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  pix_out_t        out_data_i,
  output int              fail_count_o,
  output int              pending_o
);

  pix_in_t          line_mem [LineSlots][MAX_WIDTH];
  logic [SumW-1:0]  box_sum [3];
  logic [RowW-1:0]  col_pos;
  logic [RowW-1:0]  row_pos;

  logic             cfg_en;
  logic [1:0]       cfg_pat;
  logic [3:0]       cfg_fac;
  logic [DimW-1:0]  cfg_w;
  logic [DimW-1:0]  cfg_h;

  pix_out_t         expected_pix [$];
  int               fails;
  int               reported;

  function automatic logic [SampleW-1:0] sample_of(input pix_in_t w, input int ch);
    case (ch)
      0: return w.luma_in;
      1: return w.cb_in;
      default: return w.cr_in;
    endcase
  endfunction

  function automatic pix_out_t box_avg(input int shift);
    pix_out_t r;
    r.luma_out = SampleW'(box_sum[0] >> shift);
    r.cb_out   = SampleW'(box_sum[1] >> shift);
    r.cr_out   = SampleW'(box_sum[2] >> shift);
    return r;
  endfunction

  task automatic step_position();
    logic [DimW-1:0] eff_w;
    logic [DimW-1:0] eff_h;
    eff_w = (cfg_w == '0) ? DimW'(1) : (cfg_w > MAX_WIDTH) ? DimW'(MAX_WIDTH) : cfg_w;
    eff_h = (cfg_h == '0) ? DimW'(1) : (cfg_h > MaxHeight) ? MaxHeight : cfg_h;
    // A counter left beyond a shrunken limit wraps on this step.
    if ({1'b0, col_pos} + DimW'(1) >= eff_w) begin
      col_pos = '0;
      if ({1'b0, row_pos} + DimW'(1) >= eff_h) begin
        row_pos = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic predict_pixel(input pix_in_t p);
    logic [SumW-1:0] add;
    logic [1:0]      rpos;
    logic [1:0]      cpos;
    pix_out_t        res;
    logic            have;
    have = 1'b0;
    res  = '0;
    rpos = row_pos[1:0];
    cpos = col_pos[1:0];
    if (!cfg_en) begin
      res.luma_out = p.luma_in;
      res.cb_out   = p.cb_in;
      res.cr_out   = p.cr_in;
      have = 1'b1;
    end else if (cfg_pat == PatCosited && cfg_fac == Factor2) begin
      if (!row_pos[0]) begin
        line_mem[0][col_pos] = p;
      end else begin
        for (int ch = 0; ch < 3; ch++) begin
          add = sample_of(p, ch) + sample_of(line_mem[0][col_pos], ch);
          box_sum[ch] = col_pos[0] ? box_sum[ch] + add : add;
        end
        if (col_pos[0]) begin
          res  = box_avg(2);
          have = 1'b1;
        end
      end
    end else if (cfg_pat == PatCosited && cfg_fac == Factor4 && STORED_LINES >= 3) begin
      if (rpos != 2'd3) begin
        line_mem[rpos][col_pos] = p;
      end else begin
        for (int ch = 0; ch < 3; ch++) begin
          add = sample_of(p, ch) + sample_of(line_mem[0][col_pos], ch)
              + sample_of(line_mem[1][col_pos], ch) + sample_of(line_mem[2][col_pos], ch);
          box_sum[ch] = (cpos == 2'd0) ? add : box_sum[ch] + add;
        end
        if (cpos == 2'd3) begin
          res  = box_avg(4);
          have = 1'b1;
        end
      end
    end
    if (have) expected_pix.push_back(res);
    step_position();
  endtask

  task automatic flag_failure(input string what);
    fails++;
    if (reported < 10) begin
      $display("%0t: %s", $realtime, what);
      reported++;
    end
  endtask

  task automatic check_result(input pix_out_t got);
    pix_out_t want;
    if (expected_pix.size() == 0) begin
      flag_failure($sformatf("output beat with nothing expected: Y=%0d U=%0d V=%0d",
                             got.luma_out, got.cb_out, got.cr_out));
    end else begin
      want = expected_pix.pop_front();
      if (got.luma_out !== want.luma_out || got.cb_out !== want.cb_out ||
          got.cr_out !== want.cr_out) begin
        flag_failure($sformatf("mismatch: expected Y=%0d U=%0d V=%0d, got Y=%0d U=%0d V=%0d",
                               want.luma_out, want.cb_out, want.cr_out,
                               got.luma_out, got.cb_out, got.cr_out));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos  = '0;
      row_pos  = '0;
      cfg_en   = 1'b0;
      cfg_pat  = PatCosited;
      cfg_fac  = Factor2;
      cfg_w    = DimW'(1920);
      cfg_h    = DimW'(1080);
      for (int ch = 0; ch < 3; ch++) box_sum[ch] = '0;
      expected_pix.delete();
      fails    = 0;
      reported = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgEnable:  cfg_en  = cfg_wdata_i[0];
          CfgPattern: cfg_pat = cfg_wdata_i[1:0];
          CfgFactor:  cfg_fac = cfg_wdata_i[3:0];
          CfgWidth:   cfg_w   = cfg_wdata_i;
          CfgHeight:  cfg_h   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_pixel(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      fail_count_o <= fails;
      pending_o    <= expected_pix.size();
    end
  end

endmodule

// ----- bench/tb_yuv_box_downscaler_core.sv -----
// Top of the YUV box downscaler bench: clock, reset, pixel and config stimulus, verdict.
// Depends on yuv_bds_pkg, yuv_box_downscaler_core and yuv_box_downscaler_checker.
module tb_yuv_box_downscaler_core;
  import yuv_bds_pkg::*;

  localparam int unsigned     CycleLimit   = 4_000_000;
  localparam int unsigned     RandomItems  = 1500;
  localparam int unsigned     SettleCycles = 6;
  localparam int unsigned     MaxWidth     = 8192;
  localparam int unsigned     WideRun      = 40;
  localparam logic [2:0]      CfgUnused    = 3'd7;
  localparam logic [3:0]      FactorMax    = 4'hF;
  localparam logic [DimW-1:0] DimMax       = '1;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [2:0]      cfg_idx   = CfgEnable;
  logic [DimW-1:0] cfg_wdata = '0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  pix_in_t         in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  pix_out_t        out_data;

  int              fail_count;
  int              pending;
  int unsigned     counted = 0;
  int unsigned     cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  yuv_box_downscaler_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  yuv_box_downscaler_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(input logic burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return SampleW'($urandom_range(0, 1023));
  endfunction

  function automatic pix_in_t mk_pix(input logic [SampleW-1:0] y, input logic [SampleW-1:0] u,
                                     input logic [SampleW-1:0] v);
    pix_in_t p;
    p.luma_in = y;
    p.cb_in   = u;
    p.cr_in   = v;
    return p;
  endfunction

  function automatic pix_in_t rand_pix();
    return mk_pix(rand_sample(), rand_sample(), rand_sample());
  endfunction

  // Narrow registers sometimes carry junk above their used bits.
  function automatic logic [DimW-1:0] cfg_word(input logic [DimW-1:0] val, input int width);
    logic [DimW-1:0] junk;
    junk = DimW'($urandom) << width;
    return $urandom_range(0, 1) ? val : (val | junk);
  endfunction

  function automatic int unsigned eff_dim(input logic [DimW-1:0] d);
    if (d == '0) return 1;
    if (d > MaxWidth) return MaxWidth;
    return 32'(d);
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 10) return DimMax;
    if (r < 15) return DimW'($urandom_range(13, 40));
    return DimW'($urandom_range(1, 12));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [DimW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic en, input logic [1:0] pat, input logic [3:0] fac,
                          input logic [DimW-1:0] w, input logic [DimW-1:0] h);
    write_reg(CfgEnable, cfg_word(DimW'(en), 1));
    write_reg(CfgPattern, cfg_word(DimW'(pat), 2));
    write_reg(CfgFactor, cfg_word(DimW'(fac), 4));
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
    if ($urandom_range(0, 4) == 0) write_reg(CfgUnused, DimW'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input pix_in_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every expected beat has come back.
  task automatic wait_idle(input int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic send_run(input int unsigned n, input logic burst);
    int unsigned gap;
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(rand_pix());
      if ($urandom_range(0, 199) == 0) begin
        wait_idle(0);
      end else begin
        gap = pick_gap(burst);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // A one-pixel frame in pass-through mode brings the raster position back to the origin,
  // so a scaling phase never reads a line store entry it has not written.
  task automatic realign();
    set_mode(1'b0, 2'($urandom), 4'($urandom), DimW'(1), DimW'(1));
    send_pixel(rand_pix());
    wait_idle(SettleCycles);
  endtask

  task automatic run_phase();
    logic            en;
    logic [1:0]      pat;
    logic [3:0]      fac;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic            burst;
    logic            supported;
    int unsigned     kind;
    int unsigned     frame;
    int unsigned     n;
    int unsigned     n1;
    kind      = $urandom_range(0, 99);
    w         = pick_dim();
    h         = pick_dim();
    supported = (kind < 70);
    en        = 1'b1;
    pat       = PatCosited;
    fac       = (kind < 45) ? Factor2 : Factor4;
    if (kind >= 70 && kind < 88) begin
      en  = 1'b0;
      pat = 2'($urandom);
      fac = 4'($urandom);
    end else if (kind >= 88) begin
      if ($urandom_range(0, 1)) begin
        pat = 2'($urandom_range(1, 3));
        fac = 4'($urandom);
      end else begin
        do fac = 4'($urandom); while (fac == Factor2 || fac == Factor4);
      end
    end
    frame = eff_dim(w) * eff_dim(h);
    if ($urandom_range(0, 3) != 0) begin
      n = frame * $urandom_range(1, 3);
      if (n > 240) n = $urandom_range(1, 240);
    end else begin
      n = $urandom_range(1, 60);
    end
    burst = ($urandom_range(0, 3) == 0);
    if (supported) realign();
    set_mode(en, pat, fac, w, h);
    if (supported && n > 1 && $urandom_range(0, 3) == 0) begin
      // Shrinking the width mid-frame is safe: every column still read was written.
      n1 = $urandom_range(1, n - 1);
      send_run(n1, burst);
      wait_idle(SettleCycles);
      set_mode(en, pat, fac, DimW'($urandom_range(0, eff_dim(w))),
               DimW'($urandom_range(0, 16)));
      send_run(n - n1, burst);
    end else begin
      send_run(n, burst);
    end
    if (kind < 88) counted += n;
    wait_idle(SettleCycles);
  endtask

  initial begin
    int unsigned hi;
    @(posedge clk);
    forever begin
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (hi) @(posedge clk);
      out_ready <= 1'b0;
      repeat (pick_gap(1'b0) + 1) @(posedge clk);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pass-through straight out of reset.
    send_pixel(mk_pix('0, '0, '0));
    send_pixel(mk_pix('1, '1, '1));
    send_pixel(mk_pix(10'h2AA, 10'h155, 10'h2AA));
    wait_idle(SettleCycles);

    // 2x2 on a 3x3 frame: the third column is a leftover; the third row is not sent.
    realign();
    set_mode(1'b1, PatCosited, Factor2, DimW'(3), DimW'(3));
    send_pixel(mk_pix('1, '1, '1));
    send_pixel(mk_pix('1, '0, 10'd512));
    send_pixel(mk_pix(10'd7, 10'd7, 10'd7));
    send_pixel(mk_pix('1, '1, '1));
    send_pixel(mk_pix('1, '0, 10'd512));
    send_pixel(mk_pix(10'd9, 10'd9, 10'd9));
    wait_idle(SettleCycles);

    // One full 4x4 block with full-scale luma.
    realign();
    set_mode(1'b1, PatCosited, Factor4, DimW'(4), DimW'(4));
    for (int i = 0; i < 16; i++) begin
      send_pixel(mk_pix('1, SampleW'(i * 68), (i % 2) ? '1 : '0));
    end
    wait_idle(SettleCycles);

    // Unsupported layouts give nothing.
    set_mode(1'b1, 2'($urandom_range(1, 3)), Factor2, DimW'(4), DimW'(4));
    send_pixel(rand_pix());
    wait_idle(SettleCycles);
    set_mode(1'b1, PatCosited, FactorMax, DimW'(4), DimW'(4));
    send_pixel(rand_pix());
    wait_idle(SettleCycles);

    // Oversized frame clamps to the widest row; a short run stays in the first row.
    realign();
    set_mode(1'b1, PatCosited, Factor2, DimMax, DimMax);
    send_run(WideRun, 1'b1);
    wait_idle(SettleCycles);

    while (counted < RandomItems) run_phase();

    wait_idle(4 * SettleCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- yuv_box_downscaler_core.f -----
+incdir+design
design/yuv_bds_pkg.sv
design/yuv_bds_ram.sv
design/yuv_box_downscaler_core.sv
bench/yuv_box_downscaler_checker.sv
bench/tb_yuv_box_downscaler_core.sv
